@@ design/hfcc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hfcc_pkg;

	localparam int HFCC_MAX_FRAME  = 32768;
	localparam int HFCC_MAX_HEADER = 4;
	localparam int MIN_FRAME       = 9;
	localparam int CFG_BYTES       = 4;

	localparam logic [2:0] REG_HDR_LEN   = 3'd0;
	localparam logic [2:0] REG_HDR_BYTE0 = 3'd1;
	localparam logic [2:0] REG_HDR_BYTE1 = 3'd2;
	localparam logic [2:0] REG_HDR_BYTE2 = 3'd3;
	localparam logic [2:0] REG_HDR_BYTE3 = 3'd4;

	typedef enum logic [1:0] {
		ST_GOOD     = 2'd0,
		ST_BAD      = 2'd1,
		ST_SHORT    = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		logic        match;
		logic [15:0] rx_crc;
		logic [7:0]  feed_byte;
	} win_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] frame_length;
		logic [15:0] crc_received;
		logic [15:0] crc_calc;
	} res_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = {crc[7:0], crc[15:8]};
		c = c ^ {8'h00, b};
		c = c ^ {12'h000, c[7:4]};
		c = c ^ {c[3:0], 12'h000};
		c = c ^ {3'b000, c[7:0], 5'b00000};
		return c;
	endfunction

endpackage

`default_nettype wire

@@ design/hfcc_window.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hfcc_window
	import hfcc_pkg::*;
#(
	parameter int MAX_HEADER = HFCC_MAX_HEADER,
	localparam int WIN = MAX_HEADER + 2,
	localparam int HLW = $clog2(MAX_HEADER + 1),
	localparam int IW  = $clog2(WIN + 1)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           advance,
	input  wire logic [7:0]     cur,
	input  wire logic [HLW-1:0] h,
	input  wire logic [7:0]     hdr [MAX_HEADER],
	output win_t                win
);

	logic [7:0]     recent_q [WIN];
	logic [HLW-1:0] seen_q;
	logic [7:0]     hist [WIN+1];
	logic           match;

	always_comb begin
		hist[0] = cur;
		for (int k = 1; k <= WIN; k++) begin
			hist[k] = recent_q[k-1];
		end
	end

	always_comb begin
		match = (32'(seen_q) + 32'd1 >= 32'(h));
		for (int i = 0; i < MAX_HEADER; i++) begin
			if (i < 32'(h)) begin
				if (hist[IW'(32'(h) - 1 - i)] != hdr[i]) begin
					match = 1'b0;
				end
			end
		end
	end

	assign win.match     = match;
	assign win.rx_crc    = {hist[IW'(32'(h) + 1)], hist[IW'(32'(h))]};
	assign win.feed_byte = hist[IW'(32'(h) + 2)];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WIN; k++) begin
				recent_q[k] <= 8'h00;
			end
			seen_q <= '0;
		end else if (advance) begin
			recent_q[0] <= cur;
			for (int k = 1; k < WIN; k++) begin
				recent_q[k] <= recent_q[k-1];
			end
			if (32'(seen_q) < MAX_HEADER) begin
				seen_q <= seen_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ design/hfcc_frame.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hfcc_frame
	import hfcc_pkg::*;
#(
	parameter int MAX_FRAME  = HFCC_MAX_FRAME,
	parameter int MAX_HEADER = HFCC_MAX_HEADER,
	localparam int HLW = $clog2(MAX_HEADER + 1),
	localparam int CW  = $clog2(MAX_FRAME + 2)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           advance,
	input  wire logic [HLW-1:0] h,
	input  wire win_t           win,
	output logic                res_valid,
	output res_t                res
);

	logic          open_q;
	logic [CW-1:0] cnt_q;
	logic [15:0]   crc_q;
	logic [CW-1:0] cnt_n;
	logic [CW-1:0] h_ext;
	logic [CW-1:0] len;
	logic [15:0]   crc_upd;
	logic          over;

	assign cnt_n   = cnt_q + 1'b1;
	assign h_ext   = CW'(h);
	assign crc_upd = (cnt_n >= h_ext + CW'(4)) ? crc_feed(crc_q, win.feed_byte) : crc_q;
	assign len     = (cnt_n > h_ext) ? cnt_n - h_ext : '0;
	assign over    = (cnt_n > CW'(MAX_FRAME));
	assign res_valid = open_q && (win.match || over);

	always_comb begin
		res.status       = ST_OVERFLOW;
		res.frame_length = 16'(MAX_FRAME);
		res.crc_received = 16'h0000;
		res.crc_calc     = 16'h0000;
		if (win.match) begin
			res.frame_length = 16'(len);
			if (len < CW'(MIN_FRAME)) begin
				res.status = ST_SHORT;
			end else begin
				res.status       = (win.rx_crc == crc_upd) ? ST_GOOD : ST_BAD;
				res.crc_received = win.rx_crc;
				res.crc_calc     = crc_upd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			cnt_q  <= '0;
			crc_q  <= 16'h0000;
		end else if (advance) begin
			if (win.match) begin
				open_q <= 1'b1;
				cnt_q  <= h_ext;
				crc_q  <= 16'h0000;
			end else if (open_q) begin
				if (over) begin
					open_q <= 1'b0;
					cnt_q  <= '0;
					crc_q  <= 16'h0000;
				end else begin
					cnt_q <= cnt_n;
					crc_q <= crc_upd;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ design/header_delimited_frame_crc_checker.sv @@
// Channel   Handshake                  Payload
// data      data_valid / data_stall    data_byte
// result    result_valid / result_stall status, frame_length, crc_received, crc_calc
// config    wr_en                      wr_index, wr_data
//
// One byte per cycle sustained while no result stall holds it; an accepted byte
// is held in the input register, and its result is then taken into the result register.
// Header compare and the byte-wise CRC update run in the single stage between them.
// Reset clears the configuration to its defaults, the byte history and the frame state.
// A stalled result holds the stage; data_stall rises only when a byte waits behind it.
`timescale 1ns / 1ps
`default_nettype none

module header_delimited_frame_crc_checker
	import hfcc_pkg::*;
#(
	parameter int MAX_FRAME  = HFCC_MAX_FRAME,
	parameter int MAX_HEADER = HFCC_MAX_HEADER,
	localparam int HLW = $clog2(MAX_HEADER + 1)
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [2:0]  wr_index,
	input  wire logic [7:0]  wr_data,
	input  wire logic        data_valid,
	output logic             data_stall,
	input  wire logic [7:0]  data_byte,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [1:0]       status,
	output logic [15:0]      frame_length,
	output logic [15:0]      crc_received,
	output logic [15:0]      crc_calc
);

	logic [2:0]     hlen_q;
	logic [7:0]     hbyte_q [CFG_BYTES];
	logic [HLW-1:0] h_eff;
	logic [7:0]     hdr [MAX_HEADER];

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           advance;

	win_t           win;
	logic           res_valid;
	res_t           res;
	logic           out_valid_q;
	res_t           out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hlen_q     <= 3'd1;
			hbyte_q[0] <= 8'hFA;
			hbyte_q[1] <= 8'h00;
			hbyte_q[2] <= 8'h00;
			hbyte_q[3] <= 8'h00;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_HDR_LEN:   hlen_q     <= wr_data[2:0];
				REG_HDR_BYTE0: hbyte_q[0] <= wr_data;
				REG_HDR_BYTE1: hbyte_q[1] <= wr_data;
				REG_HDR_BYTE2: hbyte_q[2] <= wr_data;
				REG_HDR_BYTE3: hbyte_q[3] <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (hlen_q == 3'd0) begin
			h_eff = HLW'(1);
		end else if (32'(hlen_q) > MAX_HEADER) begin
			h_eff = HLW'(MAX_HEADER);
		end else begin
			h_eff = HLW'(hlen_q);
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_HEADER; i++) begin
			hdr[i] = 8'h00;
			if (i < CFG_BYTES) begin
				hdr[i] = hbyte_q[2'(i)];
			end
		end
	end

	assign advance    = valid_s1 && (!out_valid_q || !result_stall);
	assign data_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_valid && !data_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && !data_stall) begin
			byte_s1 <= data_byte;
		end
	end

	hfcc_window #(
		.MAX_HEADER(MAX_HEADER)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.cur    (byte_s1),
		.h      (h_eff),
		.hdr    (hdr),
		.win    (win)
	);

	hfcc_frame #(
		.MAX_FRAME (MAX_FRAME),
		.MAX_HEADER(MAX_HEADER)
	) u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.h        (h_eff),
		.win      (win),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign status       = out_q.status;
	assign frame_length = out_q.frame_length;
	assign crc_received = out_q.crc_received;
	assign crc_calc     = out_q.crc_calc;

endmodule

`default_nettype wire

@@ design/hfcc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hfcc_checker
	import hfcc_pkg::*;
#(
	parameter int MAX_FRAME = HFCC_MAX_FRAME
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        data_stall,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [1:0]  status,
	input wire logic [15:0] frame_length,
	input wire logic [15:0] crc_received,
	input wire logic [15:0] crc_calc
);

	a_stall_only_behind_result: assert property (@(posedge clk) disable iff (!arst_n)
		data_stall |-> result_valid && result_stall)
		else $error("data stalled without a stalled result");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(status)
			&& $stable(frame_length) && $stable(crc_received) && $stable(crc_calc))
		else $error("stalled result transaction changed");

	a_crc_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (status == ST_GOOD && crc_received == crc_calc)
			|| (status == ST_BAD && crc_received != crc_calc)
			|| status == ST_SHORT || status == ST_OVERFLOW)
		else $error("crc verdict disagrees with reported values");

	a_short_overflow_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == ST_SHORT || status == ST_OVERFLOW) |->
			crc_received == 16'h0000 && crc_calc == 16'h0000
			&& (status == ST_SHORT || frame_length == 16'(MAX_FRAME))
			&& (status == ST_OVERFLOW || frame_length < 16'(MIN_FRAME)))
		else $error("short or overflow result carries bad fields");

endmodule

bind header_delimited_frame_crc_checker hfcc_checker #(.MAX_FRAME(MAX_FRAME)) u_hfcc_checker (.*);

`default_nettype wire
